FILE: design/periodic_task_table_scheduler_top_macros.svh
// ============================================================================
// Assertion macros for the periodic task table scheduler
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ============================================================================
`ifndef PERIODIC_TASK_TABLE_SCHEDULER_TOP_MACROS_SVH
`define PERIODIC_TASK_TABLE_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define PTTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ptts_pkg.sv
// ============================================================================
// ptts_pkg
// Types, codes and constants of the periodic task table scheduler.
// ============================================================================
package ptts_pkg;

    localparam int NUM_SLOTS_DEF   = 8;
    localparam int RESULT_CAP      = 8;
    localparam int CNT_W           = $clog2(RESULT_CAP);
    localparam int SLOT_W          = 3;
    localparam int ID_W            = 8;
    localparam int PERIOD_W        = 16;
    localparam int DIV_W           = 8;
    localparam int WORD_W          = ID_W + 2 * PERIOD_W;
    localparam logic [DIV_W-1:0] TICK_DIVIDE_RST = 8'd4;

    // command codes
    localparam logic [2:0] FUNC_ADD      = 3'd0;
    localparam logic [2:0] FUNC_DELETE   = 3'd1;
    localparam logic [2:0] FUNC_QUERY    = 3'd2;
    localparam logic [2:0] FUNC_TICK     = 3'd3;
    localparam logic [2:0] FUNC_DISPATCH = 3'd4;

    // status codes
    localparam logic [1:0] STAT_STOPPED   = 2'd0;
    localparam logic [1:0] STAT_READY     = 2'd1;
    localparam logic [1:0] STAT_RUNNING   = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch command, restart scan at slot 0
        logic step;       // advance scan index
        logic apply;      // perform the command's update on the current slot
        logic capture;    // build a result for the current slot into the holding register
        logic emit;       // move the held result into the output register
        logic emit_last;  // marks the emitted result as final
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan;        // latched command needs a slot scan
        logic op_tick;
        logic op_dispatch;
        logic hit;         // current slot satisfies the command
        logic last_slot;
        logic cap_hit;     // next capture is the last one allowed
        logic cand_valid;
        logic out_free;
    } dp_flags_t;

endpackage

FILE: design/ptts_ctrl.sv
// ============================================================================
// ptts_ctrl
// Sequencer: command acceptance, slot scan, result hand-off.
// ============================================================================
module ptts_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ptts_pkg::dp_flags_t stat,
    output ptts_pkg::cmd_t      ctl
);

    ptts_pkg::state_t state_reg;
    ptts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        cmd_stall  = 1'b1;
        unique case (state_reg)
            ptts_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ptts_pkg::ST_READ;
                end
            end
            ptts_pkg::ST_READ:
            begin
                // memory read of the current slot is issued here and registered for ST_EVAL
                state_next = stat.scan ? ptts_pkg::ST_EVAL : ptts_pkg::ST_IDLE;
            end
            ptts_pkg::ST_EVAL:
            begin
                if (stat.op_tick)
                begin
                    ctl.apply = stat.hit;
                    if (stat.last_slot)
                    begin
                        state_next = ptts_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ctl.step   = 1'b1;
                        state_next = ptts_pkg::ST_READ;
                    end
                end
                else if (stat.hit)
                begin
                    // wait until the previous result has somewhere to go
                    if (!stat.cand_valid || stat.out_free)
                    begin
                        ctl.emit    = stat.cand_valid;
                        ctl.apply   = 1'b1;
                        ctl.capture = 1'b1;
                        if (!stat.op_dispatch || stat.cap_hit || stat.last_slot)
                        begin
                            state_next = ptts_pkg::ST_FLUSH;
                        end
                        else
                        begin
                            ctl.step   = 1'b1;
                            state_next = ptts_pkg::ST_READ;
                        end
                    end
                end
                else if (stat.last_slot)
                begin
                    // single commands report a miss; dispatch just drains
                    ctl.capture = !stat.op_dispatch;
                    state_next  = ptts_pkg::ST_FLUSH;
                end
                else
                begin
                    ctl.step   = 1'b1;
                    state_next = ptts_pkg::ST_READ;
                end
            end
            ptts_pkg::ST_FLUSH:
            begin
                if (!stat.cand_valid)
                begin
                    state_next = ptts_pkg::ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_last = 1'b1;
                    state_next    = ptts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/ptts_datapath.sv
// ============================================================================
// ptts_datapath
// Slot table memory, ready and valid flags, prescaler, result registers.
// ============================================================================
module ptts_datapath
#(
    parameter int NUM_SLOTS = ptts_pkg::NUM_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptts_pkg::cmd_t                ctl,
    output ptts_pkg::dp_flags_t           stat,
    input  logic [2:0]                    func,
    input  logic [ptts_pkg::ID_W-1:0]     task_id,
    input  logic [ptts_pkg::PERIOD_W-1:0] task_period,
    input  logic                          cfg_write_en,
    input  logic [ptts_pkg::DIV_W-1:0]    cfg_write_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [ptts_pkg::ID_W-1:0]     result_id,
    output logic [ptts_pkg::SLOT_W-1:0]   slot_index,
    output logic [1:0]                    task_status,
    output logic                          ok,
    output logic                          due,
    output logic                          last
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int ID_W  = ptts_pkg::ID_W;
    localparam int PW    = ptts_pkg::PERIOD_W;
    localparam int DW    = ptts_pkg::DIV_W;
    localparam int CW    = ptts_pkg::CNT_W;
    localparam int WW    = ptts_pkg::WORD_W;
    localparam int SW    = ptts_pkg::SLOT_W;

    // word layout: {id, period, delay}
    logic [WW-1:0]        mem [NUM_SLOTS];
    logic [WW-1:0]        rd_word_reg;
    logic                 rd_valid_reg;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] ready_reg;

    logic [IDX_W-1:0]     idx_reg;
    logic [2:0]           op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [PW-1:0]        period_reg;
    logic                 scan_reg;
    logic [CW-1:0]        cnt_reg;
    logic [DW-1:0]        prescale_reg;
    logic [DW-1:0]        divide_reg;

    logic                 cand_valid_reg;
    logic [ID_W-1:0]      cand_id_reg;
    logic [ptts_pkg::SLOT_W-1:0] cand_slot_reg;
    logic [1:0]           cand_status_reg;
    logic                 cand_ok_reg;
    logic                 cand_due_reg;

    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [ptts_pkg::SLOT_W-1:0] out_slot_reg;
    logic [1:0]           out_status_reg;
    logic                 out_ok_reg;
    logic                 out_due_reg;
    logic                 out_last_reg;

    logic [ID_W-1:0]      cur_id;
    logic [PW-1:0]        cur_period;
    logic [PW-1:0]        cur_delay;
    logic                 cur_ready;
    logic                 hit;
    logic                 out_free;
    logic [DW:0]          pre_next;
    logic                 pre_wrap;
    logic                 mem_we;
    logic [WW-1:0]        mem_wdata;
    logic [1:0]           cap_status;

    // never-written slots read as zero
    assign cur_id     = rd_valid_reg ? rd_word_reg[WW-1 -: ID_W] : '0;
    assign cur_period = rd_valid_reg ? rd_word_reg[2*PW-1 -: PW] : '0;
    assign cur_delay  = rd_valid_reg ? rd_word_reg[PW-1:0] : '0;
    assign cur_ready  = ready_reg[idx_reg];

    always_comb
    begin
        hit       = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = {cur_id, cur_period, cur_delay};
        unique case (op_reg)
            ptts_pkg::FUNC_ADD:
            begin
                hit       = !cur_ready;
                mem_we    = ctl.apply;
                mem_wdata = {id_reg, period_reg, period_reg};
            end
            ptts_pkg::FUNC_DELETE, ptts_pkg::FUNC_QUERY:
            begin
                hit = (cur_id == id_reg);
            end
            ptts_pkg::FUNC_TICK:
            begin
                hit       = cur_ready && (cur_delay != '0);
                mem_we    = ctl.apply;
                mem_wdata = {cur_id, cur_period, cur_delay - PW'(1)};
            end
            ptts_pkg::FUNC_DISPATCH:
            begin
                hit       = cur_ready && (cur_delay == '0);
                mem_we    = ctl.apply;
                mem_wdata = {cur_id, cur_period, cur_period};
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (op_reg == ptts_pkg::FUNC_QUERY)
        begin
            cap_status = hit ? (cur_ready ? ptts_pkg::STAT_READY : ptts_pkg::STAT_STOPPED)
                             : ptts_pkg::STAT_NOT_FOUND;
        end
        else
        begin
            cap_status = ptts_pkg::STAT_STOPPED;
        end
    end

    assign pre_next = {1'b0, prescale_reg} + (DW+1)'(1);
    assign pre_wrap = (pre_next >= {1'b0, divide_reg});
    assign out_free = !out_valid_reg || !rsp_stall;

    // slot table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_word_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            valid_reg    <= '0;
            ready_reg    <= '0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[idx_reg];
            if (ctl.apply && (op_reg == ptts_pkg::FUNC_ADD))
            begin
                valid_reg[idx_reg] <= 1'b1;
                ready_reg[idx_reg] <= 1'b1;
            end
            else if (ctl.apply && (op_reg == ptts_pkg::FUNC_DELETE))
            begin
                ready_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // command latch, scan index, prescaler, divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            op_reg       <= ptts_pkg::FUNC_ADD;
            scan_reg     <= 1'b0;
            cnt_reg      <= '0;
            prescale_reg <= '0;
            divide_reg   <= ptts_pkg::TICK_DIVIDE_RST;
        end
        else
        begin
            if (cfg_write_en)
            begin
                divide_reg <= cfg_write_data;
            end
            if (ctl.load)
            begin
                idx_reg  <= '0;
                op_reg   <= func;
                cnt_reg  <= '0;
                scan_reg <= (func == ptts_pkg::FUNC_ADD) || (func == ptts_pkg::FUNC_DELETE)
                         || (func == ptts_pkg::FUNC_QUERY)
                         || (func == ptts_pkg::FUNC_DISPATCH)
                         || ((func == ptts_pkg::FUNC_TICK) && pre_wrap);
                if (func == ptts_pkg::FUNC_TICK)
                begin
                    prescale_reg <= pre_wrap ? '0 : pre_next[DW-1:0];
                end
            end
            else
            begin
                if (ctl.step)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (ctl.capture)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            id_reg     <= task_id;
            period_reg <= task_period;
        end
    end

    // holding register for the pending result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_valid_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            cand_valid_reg <= 1'b1;
        end
        else if (ctl.emit)
        begin
            cand_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cand_id_reg     <= (op_reg == ptts_pkg::FUNC_DISPATCH) ? cur_id : id_reg;
            cand_slot_reg   <= hit ? SW'(idx_reg) : '0;
            cand_status_reg <= cap_status;
            cand_ok_reg     <= hit;
            cand_due_reg    <= (op_reg == ptts_pkg::FUNC_DISPATCH);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_id_reg     <= cand_id_reg;
            out_slot_reg   <= cand_slot_reg;
            out_status_reg <= cand_status_reg;
            out_ok_reg     <= cand_ok_reg;
            out_due_reg    <= cand_due_reg;
            out_last_reg   <= ctl.emit_last;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign result_id   = out_id_reg;
    assign slot_index  = out_slot_reg;
    assign task_status = out_status_reg;
    assign ok          = out_ok_reg;
    assign due         = out_due_reg;
    assign last        = out_last_reg;

    assign stat.scan        = scan_reg;
    assign stat.op_tick     = (op_reg == ptts_pkg::FUNC_TICK);
    assign stat.op_dispatch = (op_reg == ptts_pkg::FUNC_DISPATCH);
    assign stat.hit         = hit;
    assign stat.last_slot   = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign stat.cap_hit     = (cnt_reg == CW'(ptts_pkg::RESULT_CAP - 1));
    assign stat.cand_valid  = cand_valid_reg;
    assign stat.out_free    = out_free;

endmodule

FILE: design/periodic_task_table_scheduler_top.sv
// ============================================================================
// periodic_task_table_scheduler_top
// Table of periodic task slots: add, delete, query, tick, dispatch.
// ============================================================================
//
//  Channel  Handshake                  Payload
//  -------  -------------------------  -----------------------------------
//  cmd      cmd_valid / cmd_stall      func, task_id, task_period
//  rsp      rsp_valid / rsp_stall      result_id, slot_index, task_status,
//                                      ok, due, last
//  cfg      cfg_write_en               cfg_write_data (tick_divide)
//
//  Scan: each slot gets a memory read, then an evaluate/update step; a
//  tick that does not wrap the prescaler skips the scan.
//  Reset: flags, prescaler and tick_divide (to 4) clear at once; unwritten
//  slots read as zero through per-slot valid bits, no clearing pass.
//  Stalls: one result waits in the output register and one in a holding
//  register; the scan pauses while both are full and rsp_stall is high.
//
// ----------------------------------------------------------------------------
`include "periodic_task_table_scheduler_top_macros.svh"

module periodic_task_table_scheduler_top
#(
    parameter int NUM_SLOTS = ptts_pkg::NUM_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [2:0]                    func,
    input  logic [ptts_pkg::ID_W-1:0]     task_id,
    input  logic [ptts_pkg::PERIOD_W-1:0] task_period,
    // configuration
    input  logic                          cfg_write_en,
    input  logic [ptts_pkg::DIV_W-1:0]    cfg_write_data,
    // result channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [ptts_pkg::ID_W-1:0]     result_id,
    output logic [ptts_pkg::SLOT_W-1:0]   slot_index,
    output logic [1:0]                    task_status,
    output logic                          ok,
    output logic                          due,
    output logic                          last
);

    ptts_pkg::cmd_t      ctl;
    ptts_pkg::dp_flags_t stat;

    // sequencer: decides per slot whether to update, capture or wait
    ptts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // slot table, prescaler and result registers
    ptts_datapath
    #(
        .NUM_SLOTS (NUM_SLOTS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .func           (func),
        .task_id        (task_id),
        .task_period    (task_period),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .result_id      (result_id),
        .slot_index     (slot_index),
        .task_status    (task_status),
        .ok             (ok),
        .due            (due),
        .last           (last)
    );

    // a held result is never overwritten
    `PTTS_ASSERT_NOW(a_emit_no_overwrite, ctl.emit, !rsp_valid || !rsp_stall, "held result lost")

    // a new command is only taken once the holding register is empty
    `PTTS_ASSERT_NOW(a_idle_empty, !cmd_stall, !stat.cand_valid, "result pending at accept")

    // an emitted result shows up on the next cycle
    `PTTS_ASSERT_NEXT(a_emit_shows, ctl.emit, rsp_valid, "emitted result not presented")

endmodule

FILE: tb/periodic_task_table_scheduler_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// periodic_task_table_scheduler_checker
// Watches the command, config and reply channels of the scheduler, keeps its
// own copy of the slot table and prescaler, and checks each reply in order.
// ============================================================================
module periodic_task_table_scheduler_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_stall,
    input  logic [2:0]                    func,
    input  logic [ptts_pkg::ID_W-1:0]     task_id,
    input  logic [ptts_pkg::PERIOD_W-1:0] task_period,
    input  logic                          cfg_write_en,
    input  logic [ptts_pkg::DIV_W-1:0]    cfg_write_data,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [ptts_pkg::ID_W-1:0]     result_id,
    input  logic [ptts_pkg::SLOT_W-1:0]   slot_index,
    input  logic [1:0]                    task_status,
    input  logic                          ok,
    input  logic                          due,
    input  logic                          last,
    output int                            fail_count,
    output int                            pending
);

    localparam int SLOTS      = ptts_pkg::NUM_SLOTS_DEF;
    localparam int ID_W       = ptts_pkg::ID_W;
    localparam int SLOT_W     = ptts_pkg::SLOT_W;
    localparam int PERIOD_W   = ptts_pkg::PERIOD_W;
    localparam int DIV_W      = ptts_pkg::DIV_W;
    localparam int RESULT_CAP = ptts_pkg::RESULT_CAP;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] slot;
        logic [1:0]        status;
        logic              ok;
        logic              due;
        logic              last;
    } reply_t;

    // shadow of the task table
    logic [ID_W-1:0]     slot_id     [SLOTS];
    logic [PERIOD_W-1:0] slot_delay  [SLOTS];
    logic [PERIOD_W-1:0] slot_period [SLOTS];
    logic                slot_ready  [SLOTS];
    logic [DIV_W-1:0]    prescale;
    logic [DIV_W-1:0]    tick_divide;

    reply_t expected_replies[$];
    int     misses    = 0;
    int     backlog   = 0;
    int     reply_seq = 0;

    assign fail_count = misses;
    assign pending    = backlog;

    function automatic reply_t make_reply(input logic [ID_W-1:0] id, input int slot,
                                          input logic [1:0] status, input logic hit,
                                          input logic is_due, input logic is_last);
        reply_t r;
        r.id     = id;
        r.slot   = SLOT_W'(slot);
        r.status = status;
        r.ok     = hit;
        r.due    = is_due;
        r.last   = is_last;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        misses++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // first slot holding the id, stopped or not; -1 if none
    function automatic int find_slot(input logic [ID_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (slot_id[i] == id)
                return i;
        return -1;
    endfunction

    task automatic schedule_command(input logic [2:0] f, input logic [ID_W-1:0] id,
                                    input logic [PERIOD_W-1:0] period);
        int             hit;
        int             n_due;
        int             k;
        logic [DIV_W:0] next_count;
        hit = -1;
        case (f)
            ptts_pkg::FUNC_ADD:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && !slot_ready[i])
                        hit = i;
                if (hit >= 0)
                begin
                    slot_id[hit]     = id;
                    slot_delay[hit]  = period;
                    slot_period[hit] = period;
                    slot_ready[hit]  = 1'b1;
                    expected_replies.push_back(make_reply(id, hit, ptts_pkg::STAT_STOPPED,
                                                          1, 0, 1));
                end
                else
                    expected_replies.push_back(make_reply(id, 0, ptts_pkg::STAT_STOPPED,
                                                          0, 0, 1));
            end
            ptts_pkg::FUNC_DELETE:
            begin
                hit = find_slot(id);
                if (hit >= 0)
                begin
                    slot_ready[hit] = 1'b0;
                    expected_replies.push_back(make_reply(id, hit, ptts_pkg::STAT_STOPPED,
                                                          1, 0, 1));
                end
                else
                    expected_replies.push_back(make_reply(id, 0, ptts_pkg::STAT_STOPPED,
                                                          0, 0, 1));
            end
            ptts_pkg::FUNC_QUERY:
            begin
                hit = find_slot(id);
                if (hit >= 0)
                    expected_replies.push_back(make_reply(id, hit,
                        slot_ready[hit] ? ptts_pkg::STAT_READY : ptts_pkg::STAT_STOPPED,
                        1, 0, 1));
                else
                    expected_replies.push_back(make_reply(id, 0, ptts_pkg::STAT_NOT_FOUND,
                                                          0, 0, 1));
            end
            ptts_pkg::FUNC_TICK:
            begin
                // divider of zero behaves as one
                next_count = {1'b0, prescale} + 1'b1;
                if (next_count >= {1'b0, tick_divide})
                begin
                    prescale = '0;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_ready[i] && slot_delay[i] != '0)
                            slot_delay[i] = slot_delay[i] - 1'b1;
                end
                else
                    prescale = next_count[DIV_W-1:0];
            end
            ptts_pkg::FUNC_DISPATCH:
            begin
                n_due = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_ready[i] && slot_delay[i] == '0)
                        n_due++;
                if (n_due > RESULT_CAP)
                    n_due = RESULT_CAP;
                k = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (k < RESULT_CAP && slot_ready[i] && slot_delay[i] == '0)
                    begin
                        slot_delay[i] = slot_period[i];
                        k++;
                        expected_replies.push_back(make_reply(slot_id[i], i,
                                                              ptts_pkg::STAT_STOPPED,
                                                              1, 1, k == n_due));
                    end
            end
            default: ;  // unused codes leave everything alone
        endcase
    endtask

    task automatic check_reply();
        reply_t got;
        reply_t want;
        string  wrong;
        got   = make_reply(result_id, int'(slot_index), task_status, ok, due, last);
        wrong = "";
        reply_seq++;
        if (expected_replies.size() == 0)
        begin
            report_mismatch($sformatf("reply %0d with no command waiting: id=%h slot=%0d",
                                      reply_seq, got.id, got.slot));
            return;
        end
        want = expected_replies.pop_front();
        if (got.id !== want.id)         wrong = {wrong, " result_id"};
        if (got.slot !== want.slot)     wrong = {wrong, " slot_index"};
        if (got.status !== want.status) wrong = {wrong, " task_status"};
        if (got.ok !== want.ok)         wrong = {wrong, " ok"};
        if (got.due !== want.due)       wrong = {wrong, " due"};
        if (got.last !== want.last)     wrong = {wrong, " last"};
        if (wrong != "")
            report_mismatch($sformatf({"reply %0d bad%s: got %h/%0d/%0d/%b/%b/%b",
                                       " want %h/%0d/%0d/%b/%b/%b"},
                                      reply_seq, wrong,
                                      got.id, got.slot, got.status, got.ok, got.due, got.last,
                                      want.id, want.slot, want.status, want.ok, want.due,
                                      want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_id[i]     = '0;
                slot_delay[i]  = '0;
                slot_period[i] = '0;
                slot_ready[i]  = 1'b0;
            end
            prescale    = '0;
            tick_divide = ptts_pkg::TICK_DIVIDE_RST;
            expected_replies.delete();
            backlog = 0;
        end
        else
        begin
            // replies out come from earlier commands, so check before predicting
            if (rsp_valid && !rsp_stall)
                check_reply();
            if (cfg_write_en)
                tick_divide = cfg_write_data;
            if (cmd_valid && !cmd_stall)
                schedule_command(func, task_id, task_period);
            backlog = expected_replies.size();
        end
    end

endmodule

FILE: tb/periodic_task_table_scheduler_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// periodic_task_table_scheduler_top_tb
// Drives commands and divider writes into the task table scheduler, stalls
// the reply side, and leaves checking to the checker beside the block.
// ============================================================================
module periodic_task_table_scheduler_top_tb;

    localparam int ID_W     = ptts_pkg::ID_W;
    localparam int SLOT_W   = ptts_pkg::SLOT_W;
    localparam int PERIOD_W = ptts_pkg::PERIOD_W;
    localparam int DIV_W    = ptts_pkg::DIV_W;

    localparam int HALF_PERIOD   = 4;           // 8 ns clock
    localparam int RESET_CYCLES  = 4;
    // each slot is scanned with a read and an evaluate step; a tick leaves no
    // reply, so wait well past a full scan before touching the divider
    localparam int SETTLE_CYCLES = 2 * ptts_pkg::NUM_SLOTS_DEF + 2 + 22;
    localparam int HOLD_CYCLES   = 300;         // long reply-side hold-off
    localparam int CYCLE_LIMIT   = 400000;

    // func codes the block does not decode
    localparam logic [2:0] FUNC_SPARE_0 = 3'd5;
    localparam logic [2:0] FUNC_SPARE_1 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_2 = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    logic [2:0]          func;
    logic [ID_W-1:0]     task_id;
    logic [PERIOD_W-1:0] task_period;
    logic                cfg_write_en;
    logic [DIV_W-1:0]    cfg_write_data;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [ID_W-1:0]     result_id;
    logic [SLOT_W-1:0]   slot_index;
    logic [1:0]          task_status;
    logic                ok;
    logic                due;
    logic                last;

    int fail_count;
    int pending;
    int hold_requests = 0;   // bumped by stimulus, served by the reply side

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    periodic_task_table_scheduler_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .func           (func),
        .task_id        (task_id),
        .task_period    (task_period),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .result_id      (result_id),
        .slot_index     (slot_index),
        .task_status    (task_status),
        .ok             (ok),
        .due            (due),
        .last           (last)
    );

    periodic_task_table_scheduler_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .func           (func),
        .task_id        (task_id),
        .task_period    (task_period),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .result_id      (result_id),
        .slot_index     (slot_index),
        .task_status    (task_status),
        .ok             (ok),
        .due            (due),
        .last           (last),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // ------------------------------------------------------------------------
    // Reply side. Changes stall at the falling edge only. A hold-off request
    // from the stimulus wins over everything and keeps stall high until a
    // countdown from HOLD_CYCLES, kept here, runs out. Otherwise the stall
    // pattern switches, after a random span, between: never, light random,
    // heavy random, and a fixed beat on every third span count.
    // ------------------------------------------------------------------------
    initial
    begin
        int served;
        int held;
        int span;
        int mode;
        served    = 0;
        held      = 0;
        span      = 0;
        mode      = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (served != hold_requests)
            begin
                served++;
                held = HOLD_CYCLES;
            end
            if (held > 0)
            begin
                held--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 120);
                end
                span--;
                case (mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                    default: rsp_stall <= (span % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side helpers. Payload and valid move at the falling edge; a
    // transfer is taken as done at the first rising edge with stall low.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [2:0] f, input logic [ID_W-1:0] id,
                             input logic [PERIOD_W-1:0] period);
        @(negedge clk);
        cmd_valid   <= 1'b1;
        func        <= f;
        task_id     <= id;
        task_period <= period;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    // drop valid for an idle gap set by n
    task automatic idle_sender(input int n);
        @(negedge clk);
        cmd_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // stop sending, wait for every outstanding reply, then let any tick
    // still inside the block finish its scan
    task automatic settle_block();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // divider writes only ever land on an idle block
    task automatic write_divider(input logic [DIV_W-1:0] value);
        settle_block();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: bursts of 1..12 commands, then either no gap or a random
    // idle gap. Ids mostly come from a small pool so delete and query hit
    // live slots; periods mostly short so dispatch sees plenty of due tasks,
    // with the odd full-range value. Spare func codes go in now and then but
    // do not count toward the item budget.
    // ------------------------------------------------------------------------
    task automatic run_random_phase(input int items, input bit with_hold,
                                    input bit with_pause);
        int                  sent;
        int                  burst;
        int                  pick;
        bit                  paused;
        logic [2:0]          f;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        sent   = 0;
        paused = 1'b0;
        // the sender keeps pushing through the hold-off so the block backs up
        if (with_hold)
            hold_requests++;
        while (sent < items)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < items; b++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)      f = ptts_pkg::FUNC_ADD;
                else if (pick < 32) f = ptts_pkg::FUNC_DELETE;
                else if (pick < 47) f = ptts_pkg::FUNC_QUERY;
                else if (pick < 77) f = ptts_pkg::FUNC_TICK;
                else if (pick < 95) f = ptts_pkg::FUNC_DISPATCH;
                else if (pick < 97) f = FUNC_SPARE_0;
                else if (pick < 99) f = FUNC_SPARE_1;
                else                f = FUNC_SPARE_2;
                id = ($urandom_range(0, 4) != 0) ? ID_W'($urandom_range(0, 11))
                                                 : ID_W'($urandom_range(0, 255));
                pick = $urandom_range(0, 9);
                if (pick < 7)      period = PERIOD_W'($urandom_range(0, 4));
                else if (pick < 9) period = PERIOD_W'($urandom_range(5, 40));
                else               period = PERIOD_W'($urandom_range(0, 65535));
                send_item(f, id, period);
                if (f < FUNC_SPARE_0)
                    sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
            // once per phase, if asked: let the block run completely dry
            if (with_pause && !paused && sent >= items / 2)
            begin
                paused = 1'b1;
                settle_block();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        func           = ptts_pkg::FUNC_ADD;
        task_id        = '0;
        task_period    = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, divider at its reset value of 4.
        // Empty table: every slot holds id 0, stopped, so id 0 is found.
        send_item(ptts_pkg::FUNC_QUERY,  8'h00, 16'h0000);
        send_item(ptts_pkg::FUNC_QUERY,  8'hFF, 16'h0000);   // not found
        send_item(ptts_pkg::FUNC_DELETE, 8'hFF, 16'hFFFF);   // not found
        // fill all eight slots, extreme ids and periods among them
        send_item(ptts_pkg::FUNC_ADD,    8'hFF, 16'hFFFF);
        send_item(ptts_pkg::FUNC_ADD,    8'h00, 16'h0000);
        send_item(ptts_pkg::FUNC_ADD,    8'hA5, 16'h0001);
        send_item(ptts_pkg::FUNC_ADD,    8'h5A, 16'h0002);
        send_item(ptts_pkg::FUNC_ADD,    8'h11, 16'h0000);
        send_item(ptts_pkg::FUNC_ADD,    8'h22, 16'h0000);
        send_item(ptts_pkg::FUNC_ADD,    8'h33, 16'h0000);
        send_item(ptts_pkg::FUNC_ADD,    8'h44, 16'h0000);
        send_item(ptts_pkg::FUNC_ADD,    8'h77, 16'h0003);   // table full
        send_item(ptts_pkg::FUNC_DISPATCH, 8'h00, 16'h0000); // period-zero slots only
        // four ticks make one decrement
        repeat (4) send_item(ptts_pkg::FUNC_TICK, 8'h00, 16'h0000);
        send_item(ptts_pkg::FUNC_DISPATCH, 8'h00, 16'h0000);
        // delete, then query and delete the stopped slot again
        send_item(ptts_pkg::FUNC_DELETE, 8'hA5, 16'h0000);
        send_item(ptts_pkg::FUNC_QUERY,  8'hA5, 16'h0000);
        send_item(ptts_pkg::FUNC_DELETE, 8'hA5, 16'h0000);
        // codes the block ignores
        send_item(FUNC_SPARE_0, 8'hFF, 16'hFFFF);
        send_item(FUNC_SPARE_1, 8'h00, 16'h0000);
        send_item(FUNC_SPARE_2, 8'hA5, 16'h5A5A);
        // reuses the freed slot
        send_item(ptts_pkg::FUNC_ADD,    8'h99, 16'h0000);
        send_item(ptts_pkg::FUNC_DISPATCH, 8'h00, 16'h0000);

        // Random phases across divider settings. The divider of one also
        // gets the long reply hold-off.
        write_divider(8'd1);
        run_random_phase(60, 1'b1, 1'b0);
        write_divider(8'd255);
        run_random_phase(25, 1'b0, 1'b0);
        // push the prescaler up, then drop the divider below it: the next
        // tick has to decrement straight away
        repeat (5) send_item(ptts_pkg::FUNC_TICK, 8'h00, 16'h0000);
        write_divider(8'd2);
        run_random_phase(50, 1'b0, 1'b1);
        write_divider(8'd0);                       // behaves as a divider of one
        run_random_phase(45, 1'b0, 1'b0);
        write_divider(DIV_W'($urandom_range(1, 255)));
        run_random_phase(60, 1'b0, 1'b0);

        settle_block();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
